// ===== rtl/dto_pkg.sv =====
// Shared types, widths and the microcode program of the deadband odometer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dto_pkg;

  localparam int TOTAL_WIDTH = 48;   // running total, range 33..64
  localparam int POS_W       = 32;
  localparam int THR_W       = 20;
  localparam int STEP_W      = 32;
  localparam int OUT_TOTAL_W = 48;
  localparam int PROD_W      = 2 * POS_W;
  localparam int SUM_W       = PROD_W + 2;        // sum of three squares
  localparam int ROOT_W      = SUM_W / 2;         // 33 bits
  localparam int REM_W       = ROOT_W + 2;
  localparam int CAND_W      = REM_W + 2;
  localparam int SQRT_STEPS  = SUM_W / 2;
  localparam int CNT_W       = $clog2(SQRT_STEPS);
  localparam int PC_W        = 4;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIFF,
    OP_CMP,
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_SUM,
    OP_RINIT,
    OP_RSTEP,
    OP_ADD,
    OP_FIRST,
    OP_REJECT,
    OP_OUT
  } dto_op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_IN_WAIT,
    COND_NOREF,
    COND_NOEXCEED,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } dto_cond_t;

  typedef struct packed {
    dto_op_t          op;
    dto_cond_t        cond;
    logic [PC_W-1:0]  target;
  } dto_cw_t;

  typedef struct packed {
    dto_op_t op;
  } dto_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic have_ref;
    logic no_exceed;
    logic out_busy;
  } dto_flags_t;

  localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIFF   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_CMP    = PC_W'(2);
  localparam logic [PC_W-1:0] PC_SQX    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_SQY    = PC_W'(4);
  localparam logic [PC_W-1:0] PC_SQZ    = PC_W'(5);
  localparam logic [PC_W-1:0] PC_SUM    = PC_W'(6);
  localparam logic [PC_W-1:0] PC_RINIT  = PC_W'(7);
  localparam logic [PC_W-1:0] PC_RSTEP  = PC_W'(8);
  localparam logic [PC_W-1:0] PC_ADD    = PC_W'(9);
  localparam logic [PC_W-1:0] PC_FIRST  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_REJECT = PC_W'(11);
  localparam logic [PC_W-1:0] PC_OUT    = PC_W'(12);
  localparam logic [PC_W-1:0] PC_DONE   = PC_W'(13);

  // jump to target when cond holds, else fall through to pc + 1
  function automatic dto_cw_t dto_ucode(input logic [PC_W-1:0] pc);
    dto_cw_t cw;
    case (pc)
      PC_IDLE:   cw = '{OP_IDLE,   COND_IN_WAIT,  PC_IDLE};
      PC_DIFF:   cw = '{OP_DIFF,   COND_NOREF,    PC_FIRST};
      PC_CMP:    cw = '{OP_CMP,    COND_NOEXCEED, PC_REJECT};
      PC_SQX:    cw = '{OP_SQX,    COND_NEVER,    PC_IDLE};
      PC_SQY:    cw = '{OP_SQY,    COND_NEVER,    PC_IDLE};
      PC_SQZ:    cw = '{OP_SQZ,    COND_NEVER,    PC_IDLE};
      PC_SUM:    cw = '{OP_SUM,    COND_NEVER,    PC_IDLE};
      PC_RINIT:  cw = '{OP_RINIT,  COND_NEVER,    PC_IDLE};
      PC_RSTEP:  cw = '{OP_RSTEP,  COND_CNT_NZ,   PC_RSTEP};
      PC_ADD:    cw = '{OP_ADD,    COND_ALWAYS,   PC_OUT};
      PC_FIRST:  cw = '{OP_FIRST,  COND_ALWAYS,   PC_OUT};
      PC_REJECT: cw = '{OP_REJECT, COND_NEVER,    PC_IDLE};
      PC_OUT:    cw = '{OP_OUT,    COND_OUT_BUSY, PC_OUT};
      default:   cw = '{OP_NOP,    COND_ALWAYS,   PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dto_in_if.sv =====
// Sample channel: valid/ready handshake carrying one 3-D position word.
// Depends on dto_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dto_in_if;
  import dto_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/dto_out_if.sv =====
// Result channel: valid/ready handshake carrying accept flag, step and total.
// Depends on dto_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dto_out_if;
  import dto_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [STEP_W-1:0]      step_length;
  logic [OUT_TOTAL_W-1:0] total_distance;

  modport source (output valid, output accepted, output step_length,
                  output total_distance, input ready);
  modport sink   (input valid, input accepted, input step_length,
                  input total_distance, output ready);
endinterface

`default_nettype wire

// ===== rtl/dto_sequencer.sv =====
// Microcode sequencer: program counter, loop counter and jump evaluation.
// Depends on dto_pkg (program ROM, control word and flag types).
`timescale 1ns / 1ps
`default_nettype none

module dto_sequencer
  import dto_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  dto_flags_t flags,
  output dto_ctrl_t  ctrl
);

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dto_cw_t          cw;
  logic             take;

  always_comb begin
    cw = dto_ucode(pc_r);
    case (cw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NEVER:    take = 1'b0;
      COND_IN_WAIT:  take = !flags.in_valid;
      COND_NOREF:    take = !flags.have_ref;
      COND_NOEXCEED: take = flags.no_exceed;
      COND_CNT_NZ:   take = (cnt_r != '0);
      COND_OUT_BUSY: take = flags.out_busy;
      default:       take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + PC_W'(1);

    cnt_nxt = cnt_r;
    case (cw.op)
      OP_RINIT: cnt_nxt = SQRT_LAST;
      OP_RSTEP: cnt_nxt = (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;
      default:  cnt_nxt = cnt_r;
    endcase
    ctrl.op = cw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_DONE) else $error("pc outside program");

  a_cnt_only_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> pc_r == PC_RSTEP) else $error("loop count live outside sqrt loop");

  a_loop_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PC_RSTEP |-> $past(pc_r) == PC_RINIT || $past(pc_r) == PC_RSTEP)
    else $error("sqrt loop entered without init");

endmodule

`default_nettype wire

// ===== rtl/dto_datapath.sv =====
// Datapath: input latch, deadband compare, shared squarer, bit-serial root,
// saturating total and the output register. Driven by dto_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dto_datapath
  import dto_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire [THR_W-1:0]  cfg_wdata,
  dto_in_if.sink           in_ch,
  dto_out_if.source        out_ch,
  input  dto_ctrl_t        ctrl,
  output dto_flags_t       flags
);

  logic [THR_W-1:0]          thr_r;
  logic signed [POS_W-1:0]   px_r, py_r, pz_r;
  logic signed [POS_W-1:0]   rx_r, ry_r, rz_r, rx_nxt, ry_nxt, rz_nxt;
  logic                      have_ref_r, have_ref_nxt;
  logic [POS_W-1:0]          dx_r, dy_r, dz_r;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [SUM_W-1:0]          rad_r, rad_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [TOTAL_WIDTH-1:0]    total_r, total_nxt;
  logic                      res_acc_r, res_acc_nxt;
  logic [STEP_W-1:0]         res_step_r, res_step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_acc_r;
  logic [STEP_W-1:0]         out_step_r;
  logic [OUT_TOTAL_W-1:0]    out_total_r;
  logic                      out_load;

  logic [POS_W-1:0]          mul_a;
  logic [CAND_W-1:0]         cand, trial;
  logic                      ge;
  logic [TOTAL_WIDTH:0]      tsum;

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic signed [POS_W:0] n;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    n = -d;
    return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  assign in_ch.ready     = (ctrl.op == OP_IDLE);
  assign flags.in_valid  = in_ch.valid;
  assign flags.have_ref  = have_ref_r;
  assign flags.no_exceed = !(dx_r > POS_W'(thr_r) || dy_r > POS_W'(thr_r) ||
                             dz_r > POS_W'(thr_r));
  assign flags.out_busy  = out_valid_r && !out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_acc_r;
  assign out_ch.step_length    = out_step_r;
  assign out_ch.total_distance = out_total_r;

  always_comb begin
    case (ctrl.op)
      OP_SQY:  mul_a = dy_r;
      OP_SQZ:  mul_a = dz_r;
      default: mul_a = dx_r;
    endcase
    cand  = {rem_r, rad_r[SUM_W-1 -: 2]};
    trial = CAND_W'({root_r, 2'b01});
    ge    = (cand >= trial);
    tsum  = {1'b0, total_r} + (TOTAL_WIDTH + 1)'(root_r);

    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    total_nxt     = total_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rz_nxt        = rz_r;
    have_ref_nxt  = have_ref_r;
    res_acc_nxt   = res_acc_r;
    res_step_nxt  = res_step_r;
    out_load      = 1'b0;

    case (ctrl.op)
      OP_SQX: prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_a);
      OP_SQY: begin
        prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_a);
        sum_nxt  = SUM_W'(prod_r);
      end
      OP_SQZ: begin
        prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_a);
        sum_nxt  = sum_r + SUM_W'(prod_r);
      end
      OP_SUM: sum_nxt = sum_r + SUM_W'(prod_r);
      OP_RINIT: begin
        rad_nxt  = sum_r;
        rem_nxt  = '0;
        root_nxt = '0;
      end
      OP_RSTEP: begin
        rem_nxt  = ge ? REM_W'(cand - trial) : REM_W'(cand);
        root_nxt = {root_r[ROOT_W-2:0], ge};
        rad_nxt  = {rad_r[SUM_W-3:0], 2'b00};
      end
      OP_ADD: begin
        total_nxt    = tsum[TOTAL_WIDTH] ? '1 : tsum[TOTAL_WIDTH-1:0];
        res_step_nxt = root_r[ROOT_W-1] ? '1 : root_r[STEP_W-1:0];
        res_acc_nxt  = 1'b1;
        rx_nxt       = px_r;
        ry_nxt       = py_r;
        rz_nxt       = pz_r;
        have_ref_nxt = 1'b1;
      end
      OP_FIRST: begin
        res_step_nxt = '0;
        res_acc_nxt  = 1'b1;
        rx_nxt       = px_r;
        ry_nxt       = py_r;
        rz_nxt       = pz_r;
        have_ref_nxt = 1'b1;
      end
      OP_REJECT: begin
        res_step_nxt = '0;
        res_acc_nxt  = 1'b0;
      end
      OP_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      have_ref_r  <= 1'b0;
      rx_r        <= '0;
      ry_r        <= '0;
      rz_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      have_ref_r  <= have_ref_nxt;
      rx_r        <= rx_nxt;
      ry_r        <= ry_nxt;
      rz_r        <= rz_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      px_r <= in_ch.pos_x;
      py_r <= in_ch.pos_y;
      pz_r <= in_ch.pos_z;
    end
    if (ctrl.op == OP_DIFF) begin
      dx_r <= abs_diff(px_r, rx_r);
      dy_r <= abs_diff(py_r, ry_r);
      dz_r <= abs_diff(pz_r, rz_r);
    end
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    res_acc_r  <= res_acc_nxt;
    res_step_r <= res_step_nxt;
    if (out_load) begin
      out_acc_r   <= res_acc_r;
      out_step_r  <= res_step_r;
      out_total_r <= OUT_TOTAL_W'(total_r);
    end
  end

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r)) else $error("total decreased");

  a_reject_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_acc_r |-> out_step_r == '0)
    else $error("rejected word carries a step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_RSTEP |-> (REM_W + 1)'(rem_r) <= {root_r, 2'b00} >> 1)
    else $error("sqrt remainder out of bound");

endmodule

`default_nettype wire

// ===== rtl/deadband_trajectory_odometer_core.sv =====
// Deadband path-length odometer, top level.
// Uses dto_pkg, dto_in_if, dto_out_if, dto_sequencer and dto_datapath.
//
// in_ch carries one position word (pos_x, pos_y, pos_z, signed mm) per
// valid/ready handshake; out_ch returns one word per sample: accepted flag,
// step_length (saturated to 32 bits) and the saturating 48-bit total.
// cfg_we/cfg_wdata load change_threshold (reset 100 mm); write it only while
// the block is idle.
// A microcoded sequencer steps a single datapath: one shared 32x32 squarer
// (used for x, y and z in turn) and a restoring square root, one result bit
// per cycle. Accepted sample: difference, compare, three squares, sum, root
// init, root steps, add, output; rejected sample: difference, compare,
// reject, output; first sample after reset: difference, first, output.
// in_ch.ready is high only while the sequencer waits for a sample.
// Results sit in an output register; the next sample is taken while a word
// waits there, and the sequencer holds before writing a new word until the
// old one is taken, holding for as long as out_ch.ready stays low.
// Reset (rst_n low, synchronous) clears the reference point, the total and
// the output valid, and sets the threshold to 100.
`timescale 1ns / 1ps
`default_nettype none

module deadband_trajectory_odometer_core
  import dto_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cfg_we,
  input  wire [THR_W-1:0] cfg_wdata,
  dto_in_if.sink          in_ch,
  dto_out_if.source       out_ch
);

  dto_ctrl_t  ctrl;
  dto_flags_t flags;

  dto_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dto_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ctrl      (ctrl),
    .flags     (flags)
  );

endmodule

`default_nettype wire
